// ===== rtl/tfc_pkg.sv =====
package tfc_pkg;

    localparam int OP_W   = 2;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = DATA_W + 2;

    localparam int GAIN_SHIFT = 15;
    localparam logic [DATA_W-1:0] CODE_MAX = 16'hFFFF;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;
    localparam int DEF_TABLE_DEPTH  = 65536;

    typedef enum logic [OP_W-1:0] {
        OP_TABLE_WRITE = 2'd0,
        OP_CORRECT     = 2'd1,
        OP_REPAIR      = 2'd2,
        OP_READ        = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TBL_WR,
        ST_CORR_LUT,
        ST_CORR_WB,
        ST_REP_RD,
        ST_REP_ACC,
        ST_REP_WB,
        ST_READ_RD,
        ST_READ_OUT,
        ST_EMIT_ZERO
    } state_t;

endpackage

// ===== rtl/thermal_frame_correction.sv =====
// thermal pixel correction with a temperature table and a single-port frame store.
// an item is a request taken when start is high and busy is low; busy stays high while
// the sequencer works on it and no further request is taken. a result appears on
// pixel_value and skipped for exactly one cycle marked by done and must be captured
// then, as the block cannot be held off. a table write goes straight to the table; a
// correction makes a registered multiply, then a registered table read; a read inside the
// frame makes a registered frame store read; an interior repair takes the four neighbours
// one at a time through the one frame store port and a shared adder, then writes the
// repaired value back. done is high for the first cycle after busy falls, which is also
// the first cycle in which the next request can be taken.
module thermal_frame_correction
#(
    parameter int FRAME_WIDTH  = tfc_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = tfc_pkg::DEF_FRAME_HEIGHT,
    parameter int TABLE_DEPTH  = tfc_pkg::DEF_TABLE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tfc_pkg::OP_W-1:0]    operation,
    input  logic [tfc_pkg::COL_W-1:0]   column,
    input  logic [tfc_pkg::ROW_W-1:0]   row,
    input  logic [tfc_pkg::DATA_W-1:0]  raw_sample,
    input  logic [tfc_pkg::DATA_W-1:0]  dark_level,
    input  logic [tfc_pkg::DATA_W-1:0]  gain_factor,
    input  logic [tfc_pkg::DATA_W-1:0]  table_index,
    input  logic [tfc_pkg::DATA_W-1:0]  table_value,
    output logic                        done,
    output logic [tfc_pkg::DATA_W-1:0]  pixel_value,
    output logic                        skipped
);
    import tfc_pkg::*;

    localparam int CELLS   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic                accept;
    logic                in_frame;
    logic                border;
    logic [31:0]         cell_calc;

    op_t                 op_reg;
    logic [CELL_AW-1:0]  cell_reg;
    logic                inside_reg;
    logic [TBL_AW-1:0]   tidx_reg;
    logic [DATA_W-1:0]   tval_reg;
    logic [1:0]          nb_cnt_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                done_reg;
    logic [DATA_W-1:0]   pixel_value_reg;
    logic                skipped_reg;

    logic [DATA_W-1:0]   code;

    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_addr;
    logic [DATA_W-1:0]   tbl_rdata_reg;
    logic [DATA_W-1:0]   temp_tbl_mem [TABLE_DEPTH];

    logic                fs_we;
    logic [CELL_AW-1:0]  fs_addr;
    logic [CELL_AW-1:0]  nb_addr;
    logic [DATA_W-1:0]   fs_wdata;
    logic [DATA_W-1:0]   fs_rdata_reg;
    logic [DATA_W-1:0]   frame_mem [CELLS];

    logic                acc_add;
    logic                res_load;
    logic [DATA_W-1:0]   res_value;
    logic                res_skip;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign in_frame = (32'(column) < 32'(FRAME_WIDTH)) && (32'(row) < 32'(FRAME_HEIGHT));
    assign border = (column == '0) || (32'(column) >= 32'(FRAME_WIDTH - 1)) ||
                    (row == '0) || (32'(row) >= 32'(FRAME_HEIGHT - 1));
    assign cell_calc = 32'(row) * 32'(FRAME_WIDTH) + 32'(column);

    tfc_correct u_correct
    (
        .clk         (clk),
        .load        (accept),
        .raw_sample  (raw_sample),
        .dark_level  (dark_level),
        .gain_factor (gain_factor),
        .code        (code)
    );

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(operation);
            cell_reg   <= cell_calc[CELL_AW-1:0];
            inside_reg <= in_frame;
            tidx_reg   <= table_index[TBL_AW-1:0];
            tval_reg   <= table_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            nb_cnt_reg <= '0;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_load;
            if (accept)
            begin
                nb_cnt_reg <= '0;
                acc_reg    <= '0;
            end
            else if (acc_add)
            begin
                nb_cnt_reg <= nb_cnt_reg + 2'd1;
                acc_reg    <= acc_reg + ACC_W'(fs_rdata_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pixel_value_reg <= res_value;
            skipped_reg     <= res_skip;
        end
    end

    assign done        = done_reg;
    assign pixel_value = pixel_value_reg;
    assign skipped     = skipped_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(operation))
                        OP_TABLE_WRITE: state_next = ST_TBL_WR;
                        OP_CORRECT:     state_next = ST_CORR_LUT;
                        OP_REPAIR:      state_next = border ? ST_EMIT_ZERO : ST_REP_RD;
                        OP_READ:        state_next = in_frame ? ST_READ_RD : ST_EMIT_ZERO;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TBL_WR:    state_next = ST_IDLE;
            ST_CORR_LUT:  state_next = ST_CORR_WB;
            ST_CORR_WB:   state_next = ST_IDLE;
            ST_REP_RD:    state_next = ST_REP_ACC;
            ST_REP_ACC:   state_next = (nb_cnt_reg == 2'd3) ? ST_REP_WB : ST_REP_RD;
            ST_REP_WB:    state_next = ST_IDLE;
            ST_READ_RD:   state_next = ST_READ_OUT;
            ST_READ_OUT:  state_next = ST_IDLE;
            ST_EMIT_ZERO: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // neighbours in order: above, below, left, right
    always_comb
    begin
        case (nb_cnt_reg)
            2'd0:    nb_addr = cell_reg - CELL_AW'(FRAME_WIDTH);
            2'd1:    nb_addr = cell_reg + CELL_AW'(FRAME_WIDTH);
            2'd2:    nb_addr = cell_reg - CELL_AW'(1);
            default: nb_addr = cell_reg + CELL_AW'(1);
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_addr  = code[TBL_AW-1:0];
        fs_we     = 1'b0;
        fs_addr   = cell_reg;
        fs_wdata  = tbl_rdata_reg;
        acc_add   = 1'b0;
        res_load  = 1'b0;
        res_value = '0;
        res_skip  = 1'b0;
        case (state_reg)
            ST_TBL_WR:
            begin
                tbl_we   = 1'b1;
                tbl_addr = tidx_reg;
            end
            ST_CORR_WB:
            begin
                fs_we     = inside_reg;
                res_load  = 1'b1;
                res_value = tbl_rdata_reg;
            end
            ST_REP_RD:
            begin
                fs_addr = nb_addr;
            end
            ST_REP_ACC:
            begin
                acc_add = 1'b1;
            end
            ST_REP_WB:
            begin
                fs_we     = 1'b1;
                fs_wdata  = acc_reg[ACC_W-1:2];
                res_load  = 1'b1;
                res_value = acc_reg[ACC_W-1:2];
            end
            ST_READ_OUT:
            begin
                res_load  = 1'b1;
                res_value = fs_rdata_reg;
            end
            ST_EMIT_ZERO:
            begin
                res_load = 1'b1;
                res_skip = (op_reg == OP_REPAIR);
            end
            default:
            begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            temp_tbl_mem[tbl_addr] <= tval_reg;
        end
        tbl_rdata_reg <= temp_tbl_mem[tbl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            frame_mem[fs_addr] <= fs_wdata;
        end
        fs_rdata_reg <= frame_mem[fs_addr];
    end

endmodule

// ===== rtl/tfc_correct.sv =====
module tfc_correct
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [tfc_pkg::DATA_W-1:0]  raw_sample,
    input  logic [tfc_pkg::DATA_W-1:0]  dark_level,
    input  logic [tfc_pkg::DATA_W-1:0]  gain_factor,
    output logic [tfc_pkg::DATA_W-1:0]  code
);
    import tfc_pkg::*;

    logic [DATA_W-1:0]            diff;
    logic [PROD_W-1:0]            product_reg;
    logic [PROD_W-GAIN_SHIFT-1:0] scaled;

    // dark subtraction saturates at zero
    assign diff = (raw_sample > dark_level) ? (raw_sample - dark_level) : '0;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= PROD_W'(diff) * PROD_W'(gain_factor);
        end
    end

    assign scaled = product_reg[PROD_W-1:GAIN_SHIFT];
    assign code   = (scaled > (PROD_W-GAIN_SHIFT)'(CODE_MAX)) ? CODE_MAX
                                                               : scaled[DATA_W-1:0];

endmodule

// ===== rtl/tfc_checker.sv =====
module tfc_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [tfc_pkg::OP_W-1:0]    operation,
    input  logic                        done,
    input  logic [tfc_pkg::DATA_W-1:0]  pixel_value,
    input  logic                        skipped
);
    import tfc_pkg::*;

    // a result only ever follows work on a request
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    // table writes give no result
    a_tbl_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_TABLE_WRITE)) |=> !done ##1 !done)
        else $error("result after a table write");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        skipped && done |-> (pixel_value == '0))
        else $error("refused repair with non-zero value");

endmodule

bind thermal_frame_correction tfc_checker u_tfc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .pixel_value (pixel_value),
    .skipped     (skipped)
);
